[rtl/core/ant_pkg.sv]
`timescale 1ns / 1ps

package ant_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE,
        S_EMIT
    } t_state;

    localparam logic [2:0] OP_UPDATE = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_PURGE  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_OLDEST = 3'd5;
    localparam logic [2:0] OP_LIST   = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    // Largest number of entries that one list transaction reports.
    localparam int MAX_RESULTS = 16;

endpackage

[rtl/core/ant_ram.sv]
`timescale 1ns / 1ps

module ant_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/aging_neighbor_table.sv]
`timescale 1ns / 1ps

// Neighbor table with aging. Every transaction runs one full scan of the entry
// memory through its single read port, one entry read per cycle, then a finishing
// step (S_DONE) and an emit step (S_EMIT) that loads the output register once it
// is free. A list transaction repeats the scan once per reported entry, at most
// MAX_RESULTS results in ascending key order with last on the final one. Valid
// bits live in flip-flops and are cleared by reset, so no clearing pass is needed.
// The input side stalls while a transaction is in progress; a finished result sits
// in an output register and the next input transaction may be accepted while it
// waits.
module aging_neighbor_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int TIME_WIDTH  = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_op,
    input  logic [31:0]        i_neighbor_address,
    input  logic [7:0]         i_iface_in,
    input  logic signed [31:0] i_pos_x_in,
    input  logic signed [31:0] i_pos_y_in,
    input  logic signed [31:0] i_pos_z_in,
    input  logic [47:0]        i_time_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [31:0]        o_address_out,
    output logic [7:0]         o_iface_out,
    output logic signed [31:0] o_pos_x_out,
    output logic signed [31:0] o_pos_y_out,
    output logic signed [31:0] o_pos_z_out,
    output logic [47:0]        o_time_out,
    output logic               o_last
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int Z_LO  = TIME_WIDTH;
    localparam int Y_LO  = Z_LO + 32;
    localparam int X_LO  = Y_LO + 32;
    localparam int IF_LO = X_LO + 32;
    localparam int K_LO  = IF_LO + 8;
    localparam int W     = K_LO + KEY_WIDTH;

    ant_pkg::t_state r_state, n_state;

    // Captured request.
    logic [2:0]            r_op;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [7:0]            r_iface;
    logic [31:0]           r_x, r_y, r_z;
    logic [TIME_WIDTH-1:0] r_time;

    logic [TABLE_DEPTH-1:0] r_valid;

    // Scan pipeline: r_idx issues reads, r_pidx names the slot whose data returns.
    logic [AW:0]   r_idx;
    logic          r_pv;
    logic [AW-1:0] r_pidx;

    logic                  r_hit;
    logic [AW-1:0]         r_hit_slot;
    logic [W-1:0]          r_hit_data;
    logic                  r_any;
    logic [TIME_WIDTH-1:0] r_min;
    logic                  r_best_ok;
    logic [KEY_WIDTH-1:0]  r_best_key;
    logic                  r_have_prev;
    logic [KEY_WIDTH-1:0]  r_prev;
    logic [CW-1:0]         r_cnt, r_k;

    // Result staged by the finishing step.
    logic [1:0]  r_res_status;
    logic        r_res_found, r_res_last;
    logic [31:0] r_res_addr;
    logic [7:0]  r_res_iface;
    logic [31:0] r_res_x, r_res_y, r_res_z;
    logic [47:0] r_res_time;

    // Result assembled from the scan outcome.
    logic [1:0]  n_res_status;
    logic        n_res_found, n_res_last;
    logic [31:0] n_res_addr;
    logic [7:0]  n_res_iface;
    logic [31:0] n_res_x, n_res_y, n_res_z;
    logic [47:0] n_res_time;

    // Output register.
    logic        r_ov;
    logic [1:0]  r_o_status;
    logic        r_o_found, r_o_last;
    logic [31:0] r_o_addr;
    logic [7:0]  r_o_iface;
    logic [31:0] r_o_x, r_o_y, r_o_z;
    logic [47:0] r_o_time;

    logic                  in_acc, in_ready, rd_en, scan_end, emit_load, list_more;
    logic                  wr_en, upd_ok, free_any;
    logic [AW-1:0]         free_slot, upd_slot;
    logic [W-1:0]          wr_data, rd_data;
    logic [KEY_WIDTH-1:0]  rd_key;
    logic [TIME_WIDTH-1:0] rd_stamp;
    logic                  rd_live, list_last;

    ant_ram #(
        .WIDTH (W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (upd_slot),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_key   = rd_data[K_LO +: KEY_WIDTH];
    assign rd_stamp = rd_data[0 +: TIME_WIDTH];
    assign rd_live  = r_pv && r_valid[r_pidx];

    // Lowest free slot for an insert.
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any  = 1'b1;
                free_slot = AW'(i);
            end
        end
    end

    assign upd_ok   = (r_key != '0) && (r_hit || free_any);
    assign upd_slot = r_hit ? r_hit_slot : free_slot;
    assign wr_data  = {r_key, r_iface, r_x, r_y, r_z, r_time};
    assign list_last = ({1'b0, r_k} + 1'b1 == {1'b0, r_cnt})
                    || (32'(r_k) + 32'd1 == 32'(ant_pkg::MAX_RESULTS));
    assign list_more = (r_op == ant_pkg::OP_LIST) && !r_res_last;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ant_pkg::S_IDLE: if (in_acc) n_state = ant_pkg::S_SCAN;
            ant_pkg::S_SCAN: if (scan_end) n_state = ant_pkg::S_DONE;
            ant_pkg::S_DONE: n_state = ant_pkg::S_EMIT;
            ant_pkg::S_EMIT: begin
                if (emit_load) n_state = list_more ? ant_pkg::S_SCAN : ant_pkg::S_IDLE;
            end
            default: n_state = ant_pkg::S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        scan_end  = 1'b0;
        wr_en     = 1'b0;
        emit_load = 1'b0;
        case (r_state)
            ant_pkg::S_IDLE: in_ready = 1'b1;
            ant_pkg::S_SCAN: begin
                rd_en    = (r_idx != (AW + 1)'(TABLE_DEPTH));
                scan_end = !rd_en && !r_pv;
            end
            ant_pkg::S_DONE: wr_en = (r_op == ant_pkg::OP_UPDATE) && upd_ok;
            ant_pkg::S_EMIT: emit_load = !r_ov || !i_out_stall;
            default: in_ready = 1'b0;
        endcase
    end

    // Result of the finished scan, by operation.
    always_comb begin
        n_res_status = ant_pkg::ST_OK;
        n_res_found  = 1'b0;
        n_res_last   = 1'b1;
        n_res_addr   = 32'(r_key);
        n_res_iface  = '0;
        n_res_x      = '0;
        n_res_y      = '0;
        n_res_z      = '0;
        n_res_time   = '0;
        case (r_op)
            ant_pkg::OP_UPDATE: begin
                if (r_key == '0) begin
                    n_res_status = ant_pkg::ST_INVALID;
                end else if (!upd_ok) begin
                    n_res_status = ant_pkg::ST_FULL;
                end else begin
                    n_res_found = 1'b1;
                    n_res_iface = r_iface;
                    n_res_x     = r_x;
                    n_res_y     = r_y;
                    n_res_z     = r_z;
                    n_res_time  = 48'(r_time);
                end
            end
            ant_pkg::OP_LOOKUP, ant_pkg::OP_REMOVE: begin
                if (r_hit) begin
                    n_res_found = 1'b1;
                    n_res_iface = r_hit_data[IF_LO +: 8];
                    n_res_x     = r_hit_data[X_LO +: 32];
                    n_res_y     = r_hit_data[Y_LO +: 32];
                    n_res_z     = r_hit_data[Z_LO +: 32];
                    n_res_time  = 48'(r_hit_data[0 +: TIME_WIDTH]);
                end else begin
                    n_res_status = ant_pkg::ST_NOT_FOUND;
                end
            end
            ant_pkg::OP_OLDEST: begin
                n_res_found = r_any;
                n_res_time  = 48'(r_min);
            end
            ant_pkg::OP_LIST: begin
                if (r_cnt == '0) begin
                    n_res_addr = '0;
                end else begin
                    n_res_found = 1'b1;
                    n_res_last  = list_last;
                    n_res_addr  = 32'(r_best_key);
                    n_res_iface = r_hit_data[IF_LO +: 8];
                    n_res_x     = r_hit_data[X_LO +: 32];
                    n_res_y     = r_hit_data[Y_LO +: 32];
                    n_res_z     = r_hit_data[Z_LO +: 32];
                    n_res_time  = 48'(r_hit_data[0 +: TIME_WIDTH]);
                end
            end
            default: n_res_found = 1'b0;
        endcase
    end

    assign o_in_stall = !in_ready;
    assign in_acc     = i_in_valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ant_pkg::S_IDLE;
            r_valid <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_acc) begin
                r_op        <= i_op;
                r_key       <= KEY_WIDTH'(i_neighbor_address);
                r_iface     <= i_iface_in;
                r_x         <= i_pos_x_in;
                r_y         <= i_pos_y_in;
                r_z         <= i_pos_z_in;
                r_time      <= TIME_WIDTH'(i_time_in);
                r_idx       <= '0;
                r_pv        <= 1'b0;
                r_hit       <= 1'b0;
                r_any       <= 1'b0;
                r_min       <= '1;
                r_best_ok   <= 1'b0;
                r_have_prev <= 1'b0;
                r_cnt       <= '0;
                r_k         <= '0;
            end

            if (r_state == ant_pkg::S_SCAN) begin
                if (rd_en) r_idx <= r_idx + 1'b1;
                r_pv   <= rd_en;
                r_pidx <= r_idx[AW-1:0];
                if (rd_live) begin
                    r_any <= 1'b1;
                    if (rd_stamp < r_min) r_min <= rd_stamp;
                    if (r_op == ant_pkg::OP_LIST) begin
                        if (r_k == '0) r_cnt <= r_cnt + 1'b1;
                        if ((!r_have_prev || rd_key > r_prev)
                                && (!r_best_ok || rd_key < r_best_key)) begin
                            r_best_ok  <= 1'b1;
                            r_best_key <= rd_key;
                            r_hit_data <= rd_data;
                        end
                    end else if (rd_key == r_key) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_pidx;
                        r_hit_data <= rd_data;
                    end
                    if (r_op == ant_pkg::OP_PURGE && rd_stamp <= r_time) begin
                        r_valid[r_pidx] <= 1'b0;
                    end
                end
            end

            if (r_state == ant_pkg::S_DONE) begin
                r_res_status <= n_res_status;
                r_res_found  <= n_res_found;
                r_res_last   <= n_res_last;
                r_res_addr   <= n_res_addr;
                r_res_iface  <= n_res_iface;
                r_res_x      <= n_res_x;
                r_res_y      <= n_res_y;
                r_res_z      <= n_res_z;
                r_res_time   <= n_res_time;
                if (r_op == ant_pkg::OP_UPDATE && upd_ok) begin
                    r_valid[upd_slot] <= 1'b1;
                end
                if (r_op == ant_pkg::OP_REMOVE && r_hit) begin
                    r_valid[r_hit_slot] <= 1'b0;
                end
                if (r_op == ant_pkg::OP_CLEAR) begin
                    r_valid <= '0;
                end
            end

            if (emit_load) begin
                r_ov       <= 1'b1;
                r_o_status <= r_res_status;
                r_o_found  <= r_res_found;
                r_o_last   <= r_res_last;
                r_o_addr   <= r_res_addr;
                r_o_iface  <= r_res_iface;
                r_o_x      <= r_res_x;
                r_o_y      <= r_res_y;
                r_o_z      <= r_res_z;
                r_o_time   <= r_res_time;
                if (list_more) begin
                    // Next list pass looks for the smallest key above this one.
                    r_k         <= r_k + 1'b1;
                    r_have_prev <= 1'b1;
                    r_prev      <= r_best_key;
                    r_best_ok   <= 1'b0;
                    r_idx       <= '0;
                    r_pv        <= 1'b0;
                end
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_address_out = r_o_addr;
    assign o_iface_out   = r_o_iface;
    assign o_pos_x_out   = r_o_x;
    assign o_pos_y_out   = r_o_y;
    assign o_pos_z_out   = r_o_z;
    assign o_time_out    = r_o_time;
    assign o_last        = r_o_last;

`ifndef SYNTHESIS
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ant_pkg::S_SCAN)
        else $error("accepted transaction did not start a scan");
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == ant_pkg::S_DONE && r_op == ant_pkg::OP_UPDATE))
        else $error("entry memory written outside an update");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> 32'(r_pidx) < TABLE_DEPTH)
        else $error("scan slot beyond table depth");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && r_res_last) |=> r_state == ant_pkg::S_IDLE)
        else $error("final result did not end the transaction");
`endif

endmodule
